### rtl/ppl_pkg.sv
package ppl_pkg;

    // Operation codes carried by the func field.
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_MODIFY = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;
    localparam logic [1:0] FN_BAD    = 2'd3;

    // Status codes returned with every result.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_POS = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BAD_ACT = 3'd4;

    localparam int unsigned POS_W   = 8;
    localparam int unsigned PRICE_W = 32;
    localparam int unsigned QTY_W   = 31;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_MODIFY,
        OP_DELETE
    } t_cell_op;

    // Update command from the decoder to the row of level cells.
    typedef struct packed {
        t_cell_op op;
        logic     wr_price;
        logic     wr_qty;
    } t_cell_ctrl;

endpackage

### rtl/positional_price_level_book.sv
// Positional price-level book. The block holds an ordered table of up to
// DEPTH price levels, addressed by 1-based position, and applies one
// request per item: insert at a position (later levels move down), modify
// the price and/or quantity at a position (a zero field leaves the stored
// value as it is), or delete at a position (later levels move up). An item
// is taken at any rising edge where start is high and busy is low; busy
// stays low, so a new item may be offered in every cycle. Each item yields
// exactly one result via the input and result registers, shown for a single
// cycle with o_done high: the status, the level count after the request,
// and the level now sitting at the requested position (zeros if that
// position holds no level). The receiver cannot stall, so it must capture
// every result in the cycle o_done is high. The rate of one item per cycle
// comes from the row of level cells, each of which shifts, loads or holds
// in the same cycle, so the next item always sees the updated table.
// A rejected request leaves the table untouched but still reports the
// level found at the requested position.
module positional_price_level_book #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic [ppl_pkg::POS_W-1:0]    i_position,
    input  logic [ppl_pkg::PRICE_W-1:0]  i_price,
    input  logic [ppl_pkg::QTY_W-1:0]    i_quantity,
    output logic                         o_done,
    output logic [2:0]                   o_status,
    output logic [ppl_pkg::POS_W-1:0]    o_level_count,
    output logic [ppl_pkg::PRICE_W-1:0]  o_entry_price,
    output logic [ppl_pkg::QTY_W-1:0]    o_entry_quantity
);
    import ppl_pkg::*;

    // Input register stage.
    logic               r_vld;
    logic [1:0]         r_func;
    logic [POS_W-1:0]   r_pos;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;

    // Result register stage.
    logic               r_done;
    logic [2:0]         r_status;
    logic [POS_W-1:0]   r_level_count;
    logic [PRICE_W-1:0] r_entry_price;
    logic [QTY_W-1:0]   r_entry_qty;

    t_cell_ctrl         cell_ctrl;
    logic [2:0]         status;
    logic [POS_W-1:0]   n_count;
    logic [PRICE_W-1:0] rd_price;
    logic [QTY_W-1:0]   rd_qty;
    logic               hit;
    logic               take;

    // The table updates in the cycle after capture, so there is no stall.
    assign busy = 1'b0;
    assign take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_func  <= i_func;
            r_pos   <= i_position;
            r_price <= i_price;
            r_qty   <= i_quantity;
        end
    end

    ppl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_vld),
        .i_func     (r_func),
        .i_pos      (r_pos),
        .i_price_nz (r_price != '0),
        .i_qty_nz   (r_qty != '0),
        .o_ctrl     (cell_ctrl),
        .o_status   (status),
        .o_count    (n_count)
    );

    ppl_cells #(
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk      (i_clk),
        .i_ctrl     (cell_ctrl),
        .i_pos      (r_pos),
        .i_price    (r_price),
        .i_qty      (r_qty),
        .o_rd_price (rd_price),
        .o_rd_qty   (rd_qty)
    );

    // The reported level exists only when the position lies within the
    // count after the request; otherwise the entry fields read as zero.
    assign hit = (r_pos != '0) && (r_pos <= n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_status      <= status;
            r_level_count <= n_count;
            r_entry_price <= hit ? rd_price : '0;
            r_entry_qty   <= hit ? rd_qty : '0;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_level_count    = r_level_count;
    assign o_entry_price    = r_entry_price;
    assign o_entry_quantity = r_entry_qty;

endmodule

### rtl/ppl_ctrl.sv
module ppl_ctrl #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [1:0]                 i_func,
    input  logic [ppl_pkg::POS_W-1:0]  i_pos,
    input  logic                       i_price_nz,
    input  logic                       i_qty_nz,
    output ppl_pkg::t_cell_ctrl        o_ctrl,
    output logic [2:0]                 o_status,
    output logic [ppl_pkg::POS_W-1:0]  o_count
);
    import ppl_pkg::*;

    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] n_count;
    logic [POS_W:0]   cnt_p1;
    logic             pos_zero;
    logic             pos_in_book;

    assign cnt_p1      = {1'b0, r_count} + {{POS_W{1'b0}}, 1'b1};
    assign pos_zero    = (i_pos == '0);
    assign pos_in_book = !pos_zero && (i_pos <= r_count);

    always_comb begin
        n_count         = r_count;
        o_status        = ST_OK;
        o_ctrl.op       = OP_HOLD;
        o_ctrl.wr_price = 1'b0;
        o_ctrl.wr_qty   = 1'b0;
        unique case (i_func)
            FN_INSERT: begin
                if (pos_zero || ({1'b0, i_pos} > cnt_p1)) begin
                    o_status = ST_BAD_POS;
                end else if (r_count >= POS_W'(DEPTH)) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctrl.op = OP_INSERT;
                    n_count   = cnt_p1[POS_W-1:0];
                end
            end
            FN_MODIFY: begin
                if (r_count == '0) begin
                    o_status = ST_EMPTY;
                end else if (!pos_in_book) begin
                    o_status = ST_BAD_POS;
                end else begin
                    o_ctrl.op       = OP_MODIFY;
                    o_ctrl.wr_price = i_price_nz;
                    o_ctrl.wr_qty   = i_qty_nz;
                end
            end
            FN_DELETE: begin
                if (r_count == '0) begin
                    o_status = ST_EMPTY;
                end else if (!pos_in_book) begin
                    o_status = ST_BAD_POS;
                end else begin
                    o_ctrl.op = OP_DELETE;
                    n_count   = r_count - POS_W'(1);
                end
            end
            FN_BAD: begin
                o_status = ST_BAD_ACT;
            end
        endcase
        // Nothing changes in a cycle without an item.
        if (!i_vld) begin
            n_count   = r_count;
            o_ctrl.op = OP_HOLD;
        end
    end

    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### rtl/ppl_cells.sv
module ppl_cells #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                         i_clk,
    input  ppl_pkg::t_cell_ctrl          i_ctrl,
    input  logic [ppl_pkg::POS_W-1:0]    i_pos,
    input  logic [ppl_pkg::PRICE_W-1:0]  i_price,
    input  logic [ppl_pkg::QTY_W-1:0]    i_qty,
    output logic [ppl_pkg::PRICE_W-1:0]  o_rd_price,
    output logic [ppl_pkg::QTY_W-1:0]    o_rd_qty
);
    import ppl_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PRICE_W-1:0] r_price [DEPTH];
    logic [QTY_W-1:0]   r_qty   [DEPTH];
    logic [PRICE_W-1:0] n_price [DEPTH];
    logic [QTY_W-1:0]   n_qty   [DEPTH];
    logic [POS_W-1:0]   slot;
    logic [POS_W-1:0]   pos_m1;

    // Target slot is the 1-based position less one.
    assign slot = i_pos - POS_W'(1);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_comb begin
            n_price[g] = r_price[g];
            n_qty[g]   = r_qty[g];
            unique case (i_ctrl.op)
                OP_HOLD: begin
                end
                OP_INSERT: begin
                    if (POS_W'(g) == slot) begin
                        n_price[g] = i_price;
                        n_qty[g]   = i_qty;
                    end else if (POS_W'(g) > slot) begin
                        if (g > 0) begin
                            n_price[g] = r_price[(g > 0) ? g - 1 : 0];
                            n_qty[g]   = r_qty[(g > 0) ? g - 1 : 0];
                        end
                    end
                end
                OP_MODIFY: begin
                    if (POS_W'(g) == slot) begin
                        if (i_ctrl.wr_price) begin
                            n_price[g] = i_price;
                        end
                        if (i_ctrl.wr_qty) begin
                            n_qty[g] = i_qty;
                        end
                    end
                end
                OP_DELETE: begin
                    // The last cell keeps its contents; it lies past the count.
                    if ((POS_W'(g) >= slot) && (g < DEPTH - 1)) begin
                        n_price[g] = r_price[(g < DEPTH - 1) ? g + 1 : g];
                        n_qty[g]   = r_qty[(g < DEPTH - 1) ? g + 1 : g];
                    end
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_price[g] <= n_price[g];
            r_qty[g]   <= n_qty[g];
        end
    end

    // Read port sees the table as it stands after this item.
    assign pos_m1     = slot;
    assign o_rd_price = n_price[pos_m1[IDX_W-1:0]];
    assign o_rd_qty   = n_qty[pos_m1[IDX_W-1:0]];

endmodule

### rtl/ppl_checker.sv
module ppl_checker #(
    parameter int unsigned DEPTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [2:0]                   o_status,
    input logic [ppl_pkg::POS_W-1:0]    o_level_count,
    input logic [ppl_pkg::PRICE_W-1:0]  o_entry_price,
    input logic [ppl_pkg::QTY_W-1:0]    o_entry_quantity
);
    import ppl_pkg::*;

    // Every item taken produces its result through the input and result register stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("item taken without a result two cycles later");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_EMPTY)) |-> (o_level_count == '0))
        else $error("empty status with nonzero level count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_level_count == POS_W'(DEPTH)))
        else $error("full status while the book is not full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_level_count <= POS_W'(DEPTH)))
        else $error("level count beyond the table depth");

    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_level_count == '0)) |->
            ((o_entry_price == '0) && (o_entry_quantity == '0)))
        else $error("entry reported from an empty book");

endmodule

bind positional_price_level_book ppl_checker #(
    .DEPTH (DEPTH)
) u_ppl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_status         (o_status),
    .o_level_count    (o_level_count),
    .o_entry_price    (o_entry_price),
    .o_entry_quantity (o_entry_quantity)
);
